### hw/rtl/seg_enc_pkg.sv
// Shared types and constants for the signed Elias gamma encoder.
package seg_enc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PEND_W  = BYTE_W - 1;
  localparam int unsigned PCNT_W  = 3;
  // Seven pending bits plus a 63-bit code fit in nine bytes.
  localparam int unsigned BUF_W   = 9 * BYTE_W;
  localparam int unsigned BCNT_W  = 4;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned CODE_W  = LEN_W + 1;
  localparam int unsigned TOT_W   = 7;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef struct packed {
    logic capture;
    logic lz;
    logic len;
    logic build;
    logic emit;
  } seg_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic out_free;
    logic flush;
  } seg_sts_t;

endpackage

### hw/rtl/signed_elias_gamma_encoder.sv
// Top level of the signed Elias gamma encoder with MSB-first byte packing.
//
// The input channel (in_valid, in_stall, in_action, in_value) takes one item
// per transfer. An encode item maps the signed value to a positive code number
// and appends its Elias gamma code to the bit stream; a flush item pads the
// pending bits with zeros to one final byte.
// The output channel (out_valid, out_stall, out_byte, out_last) gives one
// packed byte per transfer, the first stream bit in bit 7, and marks the
// final byte caused by an item with out_last.
// An encode item goes through mapping at capture, the two-step length search
// (LZ, LEN) and packing (BUILD), then emits one byte per cycle (up to eight)
// in EMIT while the receiver does not stall; the first byte is loaded into
// the output register there. A flush skips the length search and goes to packing.
// The output register lets a new item be accepted while the last byte of the
// previous one still waits. When the receiver stalls, byte emission pauses
// and the input side stays stalled until the item's last byte is loaded.
// A synchronous reset clears the pending bits and empties the output.
module signed_elias_gamma_encoder (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic signed [seg_enc_pkg::VALUE_W-1:0] in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [seg_enc_pkg::BYTE_W-1:0]         out_byte,
  output logic                                   out_last
);
  import seg_enc_pkg::*;

  // Command and status buses between the sequencer and the datapath.
  seg_cmd_t cmd;
  seg_sts_t sts;

  // The controller decides when to capture, search, pack and emit.
  seg_enc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the pending bits, the packing buffer and the output register.
  seg_enc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_action),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

### hw/rtl/seg_enc_dp.sv
// Datapath of the signed Elias gamma encoder: mapping, length search, packing, output.
module seg_enc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  seg_enc_pkg::seg_cmd_t             cmd,
  output seg_enc_pkg::seg_sts_t             sts,
  input  logic                              in_action,
  input  logic signed [seg_enc_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [seg_enc_pkg::BYTE_W-1:0]    out_byte,
  output logic                              out_last
);
  import seg_enc_pkg::*;

  function automatic logic [2:0] msb8(input logic [BYTE_W-1:0] b);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        p = 3'(i);
      end
    end
    return p;
  endfunction

  logic                 flush_r;
  logic [VALUE_W-1:0]   m_r;
  logic [VALUE_W-1:0]   m_nxt;
  logic [VALUE_W-1:0]   v_sat;
  logic [VALUE_W-1:0]   v_neg;
  logic [3:0]           nz_r;
  logic [3:0][2:0]      pos_r;
  logic [LEN_W-1:0]     lm1_r;
  logic [LEN_W-1:0]     lm1_nxt;
  logic [PEND_W-1:0]    pend_r;
  logic [PEND_W-1:0]    pend_nxt;
  logic [PCNT_W-1:0]    pcnt_r;
  logic [BUF_W-1:0]     buf_r;
  logic [BUF_W-1:0]     buf_nxt;
  logic [BCNT_W-1:0]    cnt_r;
  logic [CODE_W-1:0]    code_len;
  logic [TOT_W-1:0]     tot;
  logic [TOT_W-1:0]     m_shift;
  logic [14:0]          pend_sh;
  logic [BYTE_W-1:0]    pend_lo;
  logic [BYTE_W-1:0]    tail;
  logic [BYTE_W-1:0]    tail_mask;
  logic                 out_valid_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_last_r;
  logic                 out_free;
  logic                 load;

  // Zero and negative values map to odd code numbers, positive ones to even.
  always_comb begin
    v_sat = in_value;
    if (v_sat == {1'b1, {(VALUE_W-1){1'b0}}}) begin
      v_sat = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
    end
    v_neg = VALUE_W'(0) - v_sat;
    if (v_sat == '0 || v_sat[VALUE_W-1]) begin
      m_nxt = {v_neg[VALUE_W-2:0], 1'b1};
    end else begin
      m_nxt = {v_sat[VALUE_W-2:0], 1'b0};
    end
  end

  // The highest nonzero byte and its top bit give the length minus one.
  always_comb begin
    lm1_nxt = '0;
    priority if (nz_r[3]) lm1_nxt = {2'd3, pos_r[3]};
    else if (nz_r[2])     lm1_nxt = {2'd2, pos_r[2]};
    else if (nz_r[1])     lm1_nxt = {2'd1, pos_r[1]};
    else                  lm1_nxt = {2'd0, pos_r[0]};
  end

  // The code is the mapped value zero extended to 2L-1 bits.
  assign code_len = {lm1_r, 1'b1};
  assign tot      = TOT_W'(pcnt_r) + TOT_W'(code_len);
  assign m_shift  = TOT_W'(BUF_W) - tot;

  always_comb begin
    pend_sh   = {8'd0, pend_r} << code_len[2:0];
    pend_lo   = (code_len[CODE_W-1:3] != '0) ? '0 : pend_sh[BYTE_W-1:0];
    tail      = pend_lo | m_r[BYTE_W-1:0];
    tail_mask = (BYTE_W'(1) << tot[2:0]) - BYTE_W'(1);
    pend_nxt  = PEND_W'(tail & tail_mask);
    buf_nxt   = ({pend_r, {(BUF_W-PEND_W){1'b0}}} << (PCNT_W'(PEND_W) - pcnt_r));
    if (!flush_r) begin
      buf_nxt = buf_nxt | ({{(BUF_W-VALUE_W){1'b0}}, m_r} << m_shift);
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign load     = cmd.emit && out_free && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cmd.build) begin
        if (flush_r) begin
          cnt_r  <= BCNT_W'(pcnt_r != '0);
          pend_r <= '0;
          pcnt_r <= '0;
        end else begin
          cnt_r  <= tot[TOT_W-1:3];
          pend_r <= pend_nxt;
          pcnt_r <= tot[2:0];
        end
      end else if (load) begin
        cnt_r <= cnt_r - BCNT_W'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      flush_r <= (in_action == ACT_FLUSH);
      m_r     <= m_nxt;
    end
    if (cmd.lz) begin
      for (int b = 0; b < 4; b++) begin
        nz_r[b]  <= |m_r[b*BYTE_W +: BYTE_W];
        pos_r[b] <= msb8(m_r[b*BYTE_W +: BYTE_W]);
      end
    end
    if (cmd.len) begin
      lm1_r <= lm1_nxt;
    end
    if (cmd.build) begin
      buf_r <= buf_nxt;
    end else if (load) begin
      buf_r <= buf_r << BYTE_W;
    end
    if (load) begin
      out_byte_r <= buf_r[BUF_W-1 -: BYTE_W];
      out_last_r <= (cnt_r == BCNT_W'(1));
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cnt_one  = (cnt_r == BCNT_W'(1));
  assign sts.out_free = out_free;
  assign sts.flush    = (in_action == ACT_FLUSH);

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

### hw/rtl/seg_enc_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module seg_enc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  seg_enc_pkg::seg_sts_t sts,
  output seg_enc_pkg::seg_cmd_t cmd
);
  import seg_enc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LZ,
    ST_LEN,
    ST_BUILD,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = sts.flush ? ST_BUILD : ST_LZ;
        end
      end
      ST_LZ:    state_nxt = ST_LEN;
      ST_LEN:   state_nxt = ST_BUILD;
      ST_BUILD: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.cnt_zero || (sts.out_free && sts.cnt_one)) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = accept;
    cmd.lz      = (state_r == ST_LZ);
    cmd.len     = (state_r == ST_LEN);
    cmd.build   = (state_r == ST_BUILD);
    cmd.emit    = (state_r == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
